// ===== hdl/color_code_led_pulse_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Color code LED pulse encoder: assertion macros
// Assertion forms used by the encoder back end.
// ----------------------------------------------------------------------------
`ifndef COLOR_CODE_LED_PULSE_ENCODER_DEFINES_SVH
`define COLOR_CODE_LED_PULSE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ccle_pkg.sv =====
// ----------------------------------------------------------------------------
// Color code LED pulse encoder package
// Types, constants and the color code table shared by the encoder files.
// ----------------------------------------------------------------------------
package ccle_pkg;

	// Default geometry of the LED lines.
	localparam int LINES_DEF          = 9;
	localparam int CODES_PER_LINE_DEF = 6;

	// Symbols per code and the slot index of the reset gap.
	localparam int BITS_PER_CODE = 24;
	localparam int IDX_W         = $clog2(BITS_PER_CODE + 1);

	// Field widths.
	localparam int CODE_W  = 3;
	localparam int LINE_W  = 4;
	localparam int HIGH_W  = 8;
	localparam int LOW_W   = 12;
	localparam int WDATA_W = 12;
	localparam int WIDX_W  = 3;

	// Register reset values.
	localparam logic [HIGH_W-1:0] ZERO_HIGH_RST = 8'd8;
	localparam logic [HIGH_W-1:0] ZERO_LOW_RST  = 8'd17;
	localparam logic [HIGH_W-1:0] ONE_HIGH_RST  = 8'd16;
	localparam logic [HIGH_W-1:0] ONE_LOW_RST   = 8'd7;
	localparam logic [LOW_W-1:0]  GAP_RST       = 12'd1020;

	// Register indexes of the write port.
	typedef enum logic [WIDX_W-1:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_GAP       = 3'd4
	} reg_idx_t;

	// Pulse timing configuration.
	typedef struct packed {
		logic [HIGH_W-1:0] zero_high_time;
		logic [HIGH_W-1:0] zero_low_time;
		logic [HIGH_W-1:0] one_high_time;
		logic [HIGH_W-1:0] one_low_time;
		logic [LOW_W-1:0]  gap_time;
	} cfg_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [2:0]        bytes;
		logic              closes;
	} cmd_t;

	// One output symbol.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              is_gap;
		logic              bit_value;
		logic [HIGH_W-1:0] high_time;
		logic [LOW_W-1:0]  low_time;
		logic              run_last;
	} sym_t;

	// Queue write request from the front.
	typedef struct packed {
		logic push;
	} q_wr_t;

	// Byte flags of a color code; bit 2 is the first byte sent.
	function automatic logic [2:0] code_bytes(input logic [CODE_W-1:0] code);
		logic [2:0] res;
		unique case (code)
			3'd0:    res = 3'b111;
			3'd1:    res = 3'b110;
			3'd2:    res = 3'b011;
			3'd3:    res = 3'b010;
			3'd4:    res = 3'b001;
			default: res = 3'b100;
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/ccle_in_if.sv =====
// ----------------------------------------------------------------------------
// Color code input channel
// Valid/ready channel carrying one color code per item.
// ----------------------------------------------------------------------------
interface ccle_in_if
	import ccle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] color_code;

	modport source (output valid, output color_code, input ready);
	modport sink (input valid, input color_code, output ready);
endinterface

// ===== hdl/ccle_sym_if.sv =====
// ----------------------------------------------------------------------------
// Pulse symbol output channel
// Valid/ready channel carrying one pulse symbol per item.
// ----------------------------------------------------------------------------
interface ccle_sym_if
	import ccle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [LINE_W-1:0] line;
	logic              is_gap;
	logic              bit_value;
	logic [HIGH_W-1:0] high_time;
	logic [LOW_W-1:0]  low_time;
	logic              run_last;

	modport source (output valid, output line, output is_gap, output bit_value,
		output high_time, output low_time, output run_last, input ready);
	modport sink (input valid, input line, input is_gap, input bit_value,
		input high_time, input low_time, input run_last, output ready);
endinterface

// ===== hdl/color_code_led_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// Color code LED pulse encoder
// Turns facelet color codes into serial LED pulse symbols on nine lines.
//
//   channel   dir  fields
//   codes     in   color_code
//   symbols   out  line, is_gap, bit_value, high_time, low_time, run_last
//   wr_*      in   wr_en, wr_index, wr_data (timing registers)
//
// Each item yields 24 symbols, or 25 when it closes a line, at one symbol per
// cycle unless stalled; the back end's single symbol slot sets this rate.
// A code is taken while the two-entry queue has room, so the front runs ahead.
// An item's first symbol passes the queue, cur_q and the output stage.
// Reset clears the facelet position and loads the default pulse timing.
// A stall on the symbol side holds the current symbol and fills the queue.
// ----------------------------------------------------------------------------
module color_code_led_pulse_encoder
	import ccle_pkg::*;
#(
	parameter int LINES          = LINES_DEF,
	parameter int CODES_PER_LINE = CODES_PER_LINE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ccle_in_if.sink            codes,
	ccle_sym_if.source         symbols,
	input  logic               wr_en,
	input  logic [WIDX_W-1:0]  wr_index,
	input  logic [WDATA_W-1:0] wr_data
);
	cfg_t  cfg_q;
	q_wr_t qwr;
	cmd_t  f_data;
	cmd_t  b_data;
	logic  q_full;
	logic  q_valid;
	logic  pop;

	// Timing registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high_time <= ZERO_HIGH_RST;
			cfg_q.zero_low_time  <= ZERO_LOW_RST;
			cfg_q.one_high_time  <= ONE_HIGH_RST;
			cfg_q.one_low_time   <= ONE_LOW_RST;
			cfg_q.gap_time       <= GAP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ZERO_HIGH: cfg_q.zero_high_time <= wr_data[HIGH_W-1:0];
				REG_ZERO_LOW:  cfg_q.zero_low_time  <= wr_data[HIGH_W-1:0];
				REG_ONE_HIGH:  cfg_q.one_high_time  <= wr_data[HIGH_W-1:0];
				REG_ONE_LOW:   cfg_q.one_low_time   <= wr_data[HIGH_W-1:0];
				REG_GAP:       cfg_q.gap_time       <= wr_data[LOW_W-1:0];
				default:       ;
			endcase
		end
	end

	ccle_front #(
		.LINES          (LINES),
		.CODES_PER_LINE (CODES_PER_LINE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.codes  (codes),
		.qwr    (qwr),
		.q_full (q_full),
		.qdata  (f_data)
	);

	ccle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (pop),
		.rvalid (q_valid),
		.rdata  (b_data)
	);

	ccle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (b_data),
		.pop     (pop),
		.symbols (symbols)
	);
endmodule

// ===== hdl/ccle_front.sv =====
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts color codes, tracks the line and the position within the line,
// and hands a classified item to the queue.
// ----------------------------------------------------------------------------
module ccle_front
	import ccle_pkg::*;
#(
	parameter int LINES          = LINES_DEF,
	parameter int CODES_PER_LINE = CODES_PER_LINE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ccle_in_if.sink      codes,
	output q_wr_t        qwr,
	input  logic         q_full,
	output cmd_t         qdata
);
	localparam int POS_W = (CODES_PER_LINE > 1) ? $clog2(CODES_PER_LINE) : 1;

	logic [POS_W-1:0]  pos_q;
	logic [LINE_W-1:0] line_q;
	logic              accept;
	logic              closes;

	// An item is taken whenever the queue has room.
	assign codes.ready = !q_full;
	assign accept      = codes.valid && !q_full;
	assign closes      = (pos_q == POS_W'(CODES_PER_LINE - 1));

	// Classified item for the back end.
	assign qdata.line   = line_q;
	assign qdata.bytes  = code_bytes(codes.color_code);
	assign qdata.closes = closes;
	assign qwr.push     = accept;

	// Facelet position: code within the line, then the line, wrapping at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= '0;
		end else if (accept) begin
			if (closes) begin
				pos_q <= '0;
				if (line_q == LINE_W'(LINES - 1)) begin
					line_q <= '0;
				end else begin
					line_q <= line_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule

// ===== hdl/ccle_fifo.sv =====
// ----------------------------------------------------------------------------
// Encoder item queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ccle_fifo
	import ccle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t qwr,
	input  cmd_t  wdata,
	output logic  full,
	input  logic  pop,
	output logic  rvalid,
	output cmd_t  rdata
);
	cmd_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign rvalid = (count_q != 2'd0);
	assign rdata  = mem[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (qwr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !qwr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/ccle_back.sv =====
// ----------------------------------------------------------------------------
// Encoder back end
// Expands each queued item into 24 bit symbols and an optional reset gap,
// one symbol per cycle unless stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`include "color_code_led_pulse_encoder_defines.svh"

module ccle_back
	import ccle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  cmd_t       q_data,
	output logic       pop,
	ccle_sym_if.source symbols
);
	localparam logic [IDX_W-1:0] GAP_IDX  = IDX_W'(BITS_PER_CODE);
	localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(BITS_PER_CODE - 1);

	cmd_t             cur_q;
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	sym_t             sym_q;
	logic             sym_valid_q;
	logic             advance;
	logic             last_sym;
	logic             load;
	logic             bit_val;
	sym_t             sym_next;

	// A symbol moves to the output stage when that stage is free or drains.
	assign advance  = active_q && (!sym_valid_q || symbols.ready);
	assign last_sym = cur_q.closes ? (idx_q == GAP_IDX) : (idx_q == LAST_BIT);
	assign load     = !active_q || (advance && last_sym);
	assign pop      = load && q_valid;

	// Pick the byte flag for the current bit slot.
	always_comb begin
		unique case (idx_q[IDX_W-1:3])
			2'd0:    bit_val = cur_q.bytes[2];
			2'd1:    bit_val = cur_q.bytes[1];
			default: bit_val = cur_q.bytes[0];
		endcase
	end

	// Build the next symbol from the byte flag and the pulse timing.
	always_comb begin
		sym_next.line     = cur_q.line;
		sym_next.run_last = last_sym;
		if (idx_q == GAP_IDX) begin
			sym_next.is_gap    = 1'b1;
			sym_next.bit_value = 1'b0;
			sym_next.high_time = '0;
			sym_next.low_time  = cfg.gap_time;
		end else if (bit_val) begin
			sym_next.is_gap    = 1'b0;
			sym_next.bit_value = 1'b1;
			sym_next.high_time = cfg.one_high_time;
			sym_next.low_time  = {{(LOW_W - HIGH_W){1'b0}}, cfg.one_low_time};
		end else begin
			sym_next.is_gap    = 1'b0;
			sym_next.bit_value = 1'b0;
			sym_next.high_time = cfg.zero_high_time;
			sym_next.low_time  = {{(LOW_W - HIGH_W){1'b0}}, cfg.zero_low_time};
		end
	end

	// Item sequencing: load the next item as the last symbol leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= q_valid;
			idx_q    <= '0;
		end else if (advance) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_valid_q <= 1'b0;
		end else if (advance) begin
			sym_valid_q <= 1'b1;
		end else if (symbols.ready) begin
			sym_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sym_q <= sym_next;
		end
	end

	assign symbols.valid     = sym_valid_q;
	assign symbols.line      = sym_q.line;
	assign symbols.is_gap    = sym_q.is_gap;
	assign symbols.bit_value = sym_q.bit_value;
	assign symbols.high_time = sym_q.high_time;
	assign symbols.low_time  = sym_q.low_time;
	assign symbols.run_last  = sym_q.run_last;

	// The slot index never passes the gap slot.
	`CCLE_ASSERT_IMP(a_idx_range, active_q, idx_q <= GAP_IDX, "slot index out of range")
	// A gap symbol always ends its item and carries no high time.
	`CCLE_ASSERT_IMP(a_gap_last, sym_valid_q && sym_q.is_gap,
		sym_q.run_last && sym_q.high_time == '0, "gap symbol malformed")
	// An item stays in work until its last symbol has been issued.
	`CCLE_ASSERT_NXT(a_keep_active, advance && !last_sym, active_q,
		"item dropped before its last symbol")
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Color code LED pulse encoder testbench
// Feeds color codes through a randomly idling driver and checks every pulse
// symbol against a local prediction of line, bit, timing and gap behavior.
// Timing registers are rewritten between phases, while the encoder is idle.
// ----------------------------------------------------------------------------
module testbench;
	import ccle_pkg::*;

	// Run limit in clock cycles.
	localparam int CYCLE_LIMIT = 200000;
	// Facelets across all lines before the position wraps.
	localparam int FACELETS = LINES_DEF * CODES_PER_LINE_DEF;
	// First register index that maps to no register.
	localparam int REG_INDEX_END = 5;
	// Byte flags of each color code, bit 2 is the first byte on the wire.
	localparam logic [2:0] CODE_FLAGS [8] = '{3'b111, 3'b110, 3'b011, 3'b010,
		3'b001, 3'b100, 3'b100, 3'b100};

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [WIDX_W-1:0]  wr_index;
	logic [WDATA_W-1:0] wr_data;

	ccle_in_if  codes ();
	ccle_sym_if symbols ();

	color_code_led_pulse_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.codes    (codes),
		.symbols  (symbols),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow of the timing registers and of the facelet position.
	cfg_t       timing;
	logic [5:0] facelet_pos;

	logic [CODE_W-1:0] codes_to_send [$];
	sym_t              symbols_due [$];
	sym_t              want;
	logic              code_taken;
	logic              calm;
	int                mismatches;
	int                cycles;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with the run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Prints one mismatch line and counts it; printing stops after a while.
	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	// Idle decision for either side; none while the calm stretch runs.
	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 14);
	endfunction

	// Expands one accepted color code into the symbols it must produce.
	function automatic void predict_code(input logic [CODE_W-1:0] code);
		sym_t              s;
		logic [2:0]        flags;
		logic              closes;
		logic [LINE_W-1:0] ln;
		logic              b;
		ln = LINE_W'(facelet_pos / CODES_PER_LINE_DEF);
		closes = (facelet_pos % CODES_PER_LINE_DEF) == CODES_PER_LINE_DEF - 1;
		flags = CODE_FLAGS[code];
		for (int i = 0; i < BITS_PER_CODE; i++) begin
			b = flags[2 - i / 8];
			s.line = ln;
			s.is_gap = 1'b0;
			s.bit_value = b;
			s.high_time = b ? timing.one_high_time : timing.zero_high_time;
			s.low_time = b ? LOW_W'(timing.one_low_time) : LOW_W'(timing.zero_low_time);
			s.run_last = !closes && (i == BITS_PER_CODE - 1);
			symbols_due.push_back(s);
		end
		// A code that closes its line is followed by the reset gap.
		if (closes) begin
			s.line = ln;
			s.is_gap = 1'b1;
			s.bit_value = 1'b0;
			s.high_time = '0;
			s.low_time = timing.gap_time;
			s.run_last = 1'b1;
			symbols_due.push_back(s);
		end
		facelet_pos = (facelet_pos == FACELETS - 1) ? 6'd0 : facelet_pos + 6'd1;
	endfunction

	// Register write; the shadow keeps only the register's low bits.
	task automatic write_reg(input logic [WIDX_W-1:0] idx, input logic [WDATA_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ZERO_HIGH: timing.zero_high_time = value[HIGH_W-1:0];
			REG_ZERO_LOW:  timing.zero_low_time = value[HIGH_W-1:0];
			REG_ONE_HIGH:  timing.one_high_time = value[HIGH_W-1:0];
			REG_ONE_LOW:   timing.one_low_time = value[HIGH_W-1:0];
			REG_GAP:       timing.gap_time = value[LOW_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register, including the unmapped indexes, with one value.
	task automatic write_all(input logic [WDATA_W-1:0] value);
		for (int i = 0; i < 2 ** WIDX_W; i++)
			write_reg(i[WIDX_W-1:0], value);
	endtask

	// Waits until every code is sent and every symbol has arrived, then settles.
	task automatic drain();
		while (!(codes_to_send.size() == 0 && !codes.valid && symbols_due.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			codes_to_send.push_back(CODE_W'($urandom_range(7)));
	endtask

	// Code driver: holds an item until it is taken, idles at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!codes.valid || code_taken) begin
				if (codes_to_send.size() != 0 && !idle_now()) begin
					codes.valid <= 1'b1;
					codes.color_code <= codes_to_send.pop_front();
				end else begin
					codes.valid <= 1'b0;
				end
			end
			symbols.ready <= !idle_now();
		end
	end

	// Monitor: predicts on accepted codes and checks accepted symbols.
	always @(posedge clk) begin
		if (arst_n) begin
			code_taken <= codes.valid && codes.ready;
			if (codes.valid && codes.ready)
				predict_code(codes.color_code);
			if (symbols.valid && symbols.ready) begin
				if (symbols_due.size() == 0) begin
					report_mismatch("symbol arrived with none expected");
				end else begin
					want = symbols_due.pop_front();
					if (symbols.line !== want.line)
						report_mismatch($sformatf("line %0d, expected %0d",
							symbols.line, want.line));
					if (symbols.is_gap !== want.is_gap)
						report_mismatch($sformatf("is_gap %b, expected %b",
							symbols.is_gap, want.is_gap));
					if (symbols.bit_value !== want.bit_value)
						report_mismatch($sformatf("bit_value %b, expected %b",
							symbols.bit_value, want.bit_value));
					if (symbols.high_time !== want.high_time)
						report_mismatch($sformatf("high_time %0d, expected %0d",
							symbols.high_time, want.high_time));
					if (symbols.low_time !== want.low_time)
						report_mismatch($sformatf("low_time %0d, expected %0d",
							symbols.low_time, want.low_time));
					if (symbols.run_last !== want.run_last)
						report_mismatch($sformatf("run_last %b, expected %b",
							symbols.run_last, want.run_last));
				end
			end
		end
	end

	// Reset, then the phases of stimulus with register settings in between.
	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_ZERO_HIGH;
		wr_data = '0;
		codes.valid = 1'b0;
		codes.color_code = '0;
		symbols.ready = 1'b0;
		code_taken = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		cycles = 0;
		timing.zero_high_time = ZERO_HIGH_RST;
		timing.zero_low_time = ZERO_LOW_RST;
		timing.one_high_time = ONE_HIGH_RST;
		timing.one_low_time = ONE_LOW_RST;
		timing.gap_time = GAP_RST;
		facelet_pos = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every code up and down under the reset timing.
		for (int c = 0; c < 8; c++)
			codes_to_send.push_back(CODE_W'(c));
		for (int c = 7; c >= 0; c--)
			codes_to_send.push_back(CODE_W'(c));
		drain();

		// All registers zero; the unmapped indexes get all ones and must not land.
		write_all('0);
		for (int i = REG_INDEX_END; i < 2 ** WIDX_W; i++)
			write_reg(i[WIDX_W-1:0], '1);
		queue_random(54);
		drain();

		// All ones, which overflows the narrow registers.
		write_all('1);
		queue_random(54);
		drain();

		// A long stretch with no idling on either side.
		calm = 1'b1;
		for (int r = 0; r < REG_INDEX_END; r++)
			write_reg(r[WIDX_W-1:0], WDATA_W'($urandom_range(4095)));
		queue_random(60);
		drain();
		calm = 1'b0;

		// Several random settings with shorter runs.
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < REG_INDEX_END; r++)
				write_reg(r[WIDX_W-1:0], WDATA_W'($urandom_range(4095)));
			queue_random(34);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== color_code_led_pulse_encoder.f =====
+incdir+hdl
hdl/ccle_pkg.sv
hdl/ccle_in_if.sv
hdl/ccle_sym_if.sv
hdl/ccle_front.sv
hdl/ccle_fifo.sv
hdl/ccle_back.sv
hdl/color_code_led_pulse_encoder.sv
dv/testbench.sv
